>>> sv/bfpc_pkg.sv
// Package for the byte FIFO with peek and running sums.
// Holds sizes, request codes and the stage record shared by the queue and result modules.
// No dependencies.
`timescale 1ns / 1ps

package bfpc_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 11;
    localparam int PEEK_W = 10;
    localparam int SUM_W  = ((ADDR_W > PEEK_W) ? ADDR_W : PEEK_W) + 1;
    localparam int CMP_W  = (CNT_W > PEEK_W) ? CNT_W : PEEK_W;

    typedef enum logic [2:0] {
        FN_APPEND   = 3'd0,
        FN_POP      = 3'd1,
        FN_PEEK     = 3'd2,
        FN_CLEAR    = 3'd3,
        FN_SWAP_POP = 3'd4,
        FN_SWAP_APP = 3'd5,
        FN_STATUS   = 3'd6
    } t_func;

    // Request record handed from the queue stage to the result stage.
    typedef struct packed {
        logic              valid;
        logic [2:0]        func;
        logic              hit;       // pop or peek that reads a held byte
        logic              refused;
        logic [CNT_W-1:0]  count;     // fill count after the request
        logic [7:0]        app_sum;   // appended sum after the request
        logic [7:0]        app_old;   // appended sum before the request
        logic [7:0]        data;
    } t_stage;

endpackage

>>> sv/bfpc_queue.sv
// Queue stage: byte store, pointers, fill count and appended sum.
// Reads the store at the request edge; passes a t_stage record on. Uses bfpc_pkg.
`timescale 1ns / 1ps

module bfpc_queue
    import bfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_data_byte,
    input  logic [PEEK_W-1:0] i_peek_index,
    output t_stage            o_stage,
    output logic [7:0]        o_rd_data
);

    logic [7:0]        r_mem [DEPTH];
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_app_sum, n_app_sum;
    t_stage            r_stage, n_stage;
    logic [7:0]        r_rd_data;

    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [SUM_W-1:0]  peek_sum;
    logic [SUM_W-1:0]  peek_wrap;
    logic              peek_hit;
    logic              full;
    logic              empty;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Offset from the oldest byte stays below twice the depth: one subtract wraps it.
    assign peek_sum  = SUM_W'(r_rd_ptr) + SUM_W'(i_peek_index);
    assign peek_wrap = (peek_sum >= SUM_W'(DEPTH)) ? peek_sum - SUM_W'(DEPTH) : peek_sum;
    assign peek_hit  = (CMP_W'(i_peek_index) < CMP_W'(r_count));

    function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_app_sum = r_app_sum;
        wr_en     = 1'b0;
        rd_addr   = r_rd_ptr;

        n_stage         = r_stage;
        n_stage.valid   = i_take;
        n_stage.func    = i_func;
        n_stage.hit     = 1'b0;
        n_stage.refused = 1'b0;
        n_stage.app_old = r_app_sum;
        n_stage.data    = i_data_byte;

        if (i_take) begin
            case (i_func)
                FN_APPEND: begin
                    if (full) begin
                        n_stage.refused = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        n_wr_ptr  = wrap_next(r_wr_ptr);
                        n_count   = r_count + 1'b1;
                        n_app_sum = r_app_sum + i_data_byte;
                    end
                end
                FN_POP: begin
                    if (empty) begin
                        n_stage.refused = 1'b1;
                    end else begin
                        n_stage.hit = 1'b1;
                        n_rd_ptr    = wrap_next(r_rd_ptr);
                        n_count     = r_count - 1'b1;
                    end
                end
                FN_PEEK: begin
                    n_stage.hit = peek_hit;
                    rd_addr     = ADDR_W'(peek_wrap);
                end
                FN_CLEAR: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_count  = '0;
                end
                FN_SWAP_APP: begin
                    n_app_sum = i_data_byte;
                end
                default: begin
                end
            endcase
        end

        n_stage.count   = n_count;
        n_stage.app_sum = n_app_sum;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_app_sum <= '0;
            r_stage   <= '0;
        end else begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_count   <= n_count;
            r_app_sum <= n_app_sum;
            r_stage   <= n_stage;
        end
    end

    assign o_stage   = r_stage;
    assign o_rd_data = r_rd_data;

endmodule

>>> sv/bfpc_result.sv
// Result stage: popped sum, read value selection and the result register.
// Takes the t_stage record and store read data from bfpc_queue. Uses bfpc_pkg.
`timescale 1ns / 1ps

module bfpc_result
    import bfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stage            i_stage,
    input  logic [7:0]        i_rd_data,
    output logic              o_strobe,
    output logic [7:0]        o_read_value,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_is_empty,
    output logic              o_refused,
    output logic [7:0]        o_popped_total,
    output logic [7:0]        o_appended_total
);

    logic [7:0] r_pop_sum, n_pop_sum;
    logic [7:0] n_read_value;

    logic              r_strobe;
    logic [7:0]        r_read_value;
    logic [FILL_W-1:0] r_fill_count;
    logic              r_is_empty;
    logic              r_refused;
    logic [7:0]        r_popped_total;
    logic [7:0]        r_appended_total;

    always_comb begin
        n_pop_sum    = r_pop_sum;
        n_read_value = 8'd0;
        if (i_stage.valid) begin
            case (i_stage.func)
                FN_POP: begin
                    if (i_stage.hit) begin
                        n_read_value = i_rd_data;
                        n_pop_sum    = r_pop_sum + i_rd_data;
                    end
                end
                FN_PEEK: begin
                    if (i_stage.hit) begin
                        n_read_value = i_rd_data;
                    end
                end
                FN_SWAP_POP: begin
                    n_read_value = r_pop_sum;
                    n_pop_sum    = i_stage.data;
                end
                FN_SWAP_APP: begin
                    n_read_value = i_stage.app_old;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_sum <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_pop_sum <= n_pop_sum;
            r_strobe  <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value     <= n_read_value;
        r_fill_count     <= FILL_W'(i_stage.count);
        r_is_empty       <= (i_stage.count == '0);
        r_refused        <= i_stage.refused;
        r_popped_total   <= n_pop_sum;
        r_appended_total <= i_stage.app_sum;
    end

    assign o_strobe         = r_strobe;
    assign o_read_value     = r_read_value;
    assign o_fill_count     = r_fill_count;
    assign o_is_empty       = r_is_empty;
    assign o_refused        = r_refused;
    assign o_popped_total   = r_popped_total;
    assign o_appended_total = r_appended_total;

endmodule

>>> sv/byte_fifo_peek_checksum.sv
// Top level of the byte FIFO with peek and running sums.
// Instantiates bfpc_queue and bfpc_result; uses bfpc_pkg.
//
//   channel   handshake            payload
//   request   start / busy         i_func, i_data_byte, i_peek_index
//   result    o_strobe (1 cycle)   o_read_value, o_fill_count, o_is_empty,
//                                  o_refused, o_popped_total, o_appended_total
//
// One request per cycle; busy is always low.
// Each result passes the stage register and store read at its request edge, then the
// result register, and is strobed in request order.
// The store read at the request edge and the result register set the latency.
// Synchronous active-low reset empties the queue and clears both sums; store
// contents are left as they are and are never read before being written.
// The receiver cannot stall: every result is strobed exactly once.
`timescale 1ns / 1ps

module byte_fifo_peek_checksum
    import bfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_data_byte,
    input  logic [PEEK_W-1:0] i_peek_index,
    output logic              o_strobe,
    output logic [7:0]        o_read_value,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_is_empty,
    output logic              o_refused,
    output logic [7:0]        o_popped_total,
    output logic [7:0]        o_appended_total
);

    t_stage     stage;
    logic [7:0] rd_data;
    logic       take;

    assign busy = 1'b0;
    assign take = start & ~busy;

    bfpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_peek_index (i_peek_index),
        .o_stage      (stage),
        .o_rd_data    (rd_data)
    );

    bfpc_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stage          (stage),
        .i_rd_data        (rd_data),
        .o_strobe         (o_strobe),
        .o_read_value     (o_read_value),
        .o_fill_count     (o_fill_count),
        .o_is_empty       (o_is_empty),
        .o_refused        (o_refused),
        .o_popped_total   (o_popped_total),
        .o_appended_total (o_appended_total)
    );

endmodule

>>> test/bfpc_checker.sv
// Checker for byte_fifo_peek_checksum: watches the request and result channels,
// predicts each result from its own copy of the queue and sums, and counts mismatches.
// Depends on bfpc_pkg.
`timescale 1ns / 1ps

module bfpc_checker
    import bfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_data_byte,
    input  logic [PEEK_W-1:0] i_peek_index,
    input  logic              o_strobe,
    input  logic [7:0]        o_read_value,
    input  logic [FILL_W-1:0] o_fill_count,
    input  logic              o_is_empty,
    input  logic              o_refused,
    input  logic [7:0]        o_popped_total,
    input  logic [7:0]        o_appended_total,
    output int                mismatch_count,
    output int                awaited_count
);

    typedef struct packed {
        logic [7:0]        read_value;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
        logic              refused;
        logic [7:0]        popped_total;
        logic [7:0]        appended_total;
    } t_status;

    logic [7:0]        shadow_bytes [DEPTH];
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    int unsigned       held;
    logic [7:0]        pop_sum;
    logic [7:0]        app_sum;
    t_status           awaited_status [$];
    int                fails = 0;

    initial begin
        mismatch_count = 0;
        awaited_count  = 0;
    end

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // Apply one request to the shadow queue and return the status it produces.
    function automatic t_status queue_request(input logic [2:0] func, input logic [7:0] data,
                                              input logic [PEEK_W-1:0] idx);
        t_status r;
        r = '0;
        case (t_func'(func))
            FN_APPEND: begin
                if (held >= DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    shadow_bytes[tail] = data;
                    tail = ring_next(tail);
                    held++;
                    app_sum = app_sum + data;
                end
            end
            FN_POP: begin
                if (held == 0) begin
                    r.refused = 1'b1;
                end else begin
                    r.read_value = shadow_bytes[head];
                    head = ring_next(head);
                    held--;
                    pop_sum = pop_sum + r.read_value;
                end
            end
            FN_PEEK: begin
                if (idx < held)
                    r.read_value = shadow_bytes[(int'(head) + int'(idx)) % DEPTH];
            end
            FN_CLEAR: begin
                head = '0;
                tail = '0;
                held = 0;
            end
            FN_SWAP_POP: begin
                r.read_value = pop_sum;
                pop_sum = data;
            end
            FN_SWAP_APP: begin
                r.read_value = app_sum;
                app_sum = data;
            end
            default: ;
        endcase
        r.fill_count     = FILL_W'(held);
        r.is_empty       = (held == 0);
        r.popped_total   = pop_sum;
        r.appended_total = app_sum;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (!i_rst_n) begin
            head = '0;
            tail = '0;
            held = 0;
            pop_sum = '0;
            app_sum = '0;
            awaited_status.delete();
        end else begin
            if (o_strobe) begin
                if (awaited_status.size() == 0) begin
                    $error("result strobed with no request outstanding");
                    fails++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("read_value", want.read_value, o_read_value);
                    check_field("fill_count", want.fill_count, o_fill_count);
                    check_field("is_empty", want.is_empty, o_is_empty);
                    check_field("refused", want.refused, o_refused);
                    check_field("popped_total", want.popped_total, o_popped_total);
                    check_field("appended_total", want.appended_total, o_appended_total);
                end
            end
            if (start && !busy)
                awaited_status.push_back(queue_request(i_func, i_data_byte, i_peek_index));
        end
        mismatch_count <= fails;
        awaited_count  <= awaited_status.size();
    end

endmodule

>>> test/tb_top.sv
// Testbench top for byte_fifo_peek_checksum: clock, reset and request stimulus
// in bursts; bfpc_checker does the prediction and comparison.
// Depends on bfpc_pkg, bfpc_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import bfpc_pkg::*;

    localparam logic [2:0] FN_RESERVED = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MIXED_ITEMS = 200;
    localparam int         FILL_ITEMS  = 1150;
    localparam int         DRAIN_ITEMS = 350;

    typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN} t_phase;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_func;
    logic [7:0]        i_data_byte;
    logic [PEEK_W-1:0] i_peek_index;
    logic              o_strobe;
    logic [7:0]        o_read_value;
    logic [FILL_W-1:0] o_fill_count;
    logic              o_is_empty;
    logic              o_refused;
    logic [7:0]        o_popped_total;
    logic [7:0]        o_appended_total;
    int                mismatch_count;
    int                awaited_count;
    int                cycle_count = 0;
    int                burst_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    byte_fifo_peek_checksum dut (.*);

    bfpc_checker u_checker (.*);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Issue one request; open a new burst after a random gap when the last one ran out.
    task automatic send_request(input logic [2:0] func, input logic [7:0] data,
                                input logic [PEEK_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 24);
        end
        start        <= 1'b1;
        i_func       <= func;
        i_data_byte  <= data;
        i_peek_index <= idx;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        burst_left--;
    endtask

    function automatic logic [2:0] pick_func(input t_phase phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_MIXED:
                return (roll < 30) ? FN_APPEND : (roll < 50) ? FN_POP :
                       (roll < 65) ? FN_PEEK : (roll < 70) ? FN_CLEAR :
                       (roll < 76) ? FN_SWAP_POP : (roll < 82) ? FN_SWAP_APP :
                       (roll < 92) ? FN_STATUS : FN_RESERVED;
            // mostly appends so the queue reaches full and appends get refused
            PH_FILL:
                return (roll < 91) ? FN_APPEND : (roll < 97) ? FN_PEEK :
                       (roll < 98) ? FN_POP : (roll < 99) ? FN_STATUS : FN_SWAP_APP;
            default:
                return (roll < 55) ? FN_POP : (roll < 75) ? FN_APPEND :
                       (roll < 92) ? FN_PEEK : (roll < 95) ? FN_SWAP_POP :
                       (roll < 98) ? FN_STATUS : FN_SWAP_APP;
        endcase
    endfunction

    task automatic send_random(input t_phase phase);
        logic [7:0]        data;
        logic [PEEK_W-1:0] idx;
        data = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                           : 8'($urandom_range(0, 255));
        idx  = $urandom_range(0, 1) ? PEEK_W'($urandom_range(0, 1023))
                                    : PEEK_W'($urandom_range(0, 31));
        send_request(pick_func(phase), data, idx);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FN_STATUS;
        i_data_byte  = '0;
        i_peek_index = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: refused pop, peeks with nothing held; then appends, peeks, swaps and clear
        send_request(FN_STATUS, 8'h00, 10'd0);
        send_request(FN_POP, 8'h00, 10'd0);
        send_request(FN_PEEK, 8'h00, 10'd0);
        send_request(FN_PEEK, 8'h00, 10'd1023);
        send_request(FN_SWAP_POP, 8'hFF, 10'd0);
        send_request(FN_SWAP_APP, 8'hFF, 10'd0);
        send_request(FN_APPEND, 8'h00, 10'd0);
        send_request(FN_APPEND, 8'hFF, 10'd0);
        send_request(FN_APPEND, 8'hA5, 10'd0);
        send_request(FN_PEEK, 8'h00, 10'd0);
        send_request(FN_PEEK, 8'h00, 10'd2);
        send_request(FN_PEEK, 8'h00, 10'd3);
        send_request(FN_PEEK, 8'hFF, 10'd1023);
        send_request(FN_RESERVED, 8'hFF, 10'd1023);
        send_request(FN_POP, 8'h00, 10'd0);
        send_request(FN_SWAP_POP, 8'h00, 10'd0);
        send_request(FN_SWAP_APP, 8'h00, 10'd0);
        send_request(FN_CLEAR, 8'hFF, 10'd0);
        send_request(FN_POP, 8'h00, 10'd0);
        send_request(FN_PEEK, 8'h00, 10'd0);
        send_request(FN_APPEND, 8'h5A, 10'd0);
        send_request(FN_POP, 8'h00, 10'd0);
        send_request(FN_STATUS, 8'h00, 10'd0);

        repeat (MIXED_ITEMS) send_random(PH_MIXED);
        repeat (FILL_ITEMS)  send_random(PH_FILL);
        // drain: mostly pops, with some appends
        repeat (DRAIN_ITEMS) send_random(PH_DRAIN);

        start <= 1'b0;
        while (awaited_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
